@@ hw/rtl/sauvola_local_threshold_macros.svh @@
// ----------------------------------------------------------------------------
// Sauvola local threshold - assertion macros
// Concurrent checks on clk_i, disabled while rst_ni is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SAUVOLA_LOCAL_THRESHOLD_MACROS_SVH
`define SAUVOLA_LOCAL_THRESHOLD_MACROS_SVH

`ifndef SYNTHESIS
`define SLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SLT_ASSERT(lbl, prop, msg)
`define SLT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hw/rtl/slt_pkg.sv @@
// ----------------------------------------------------------------------------
// Sauvola local threshold - package
// Shared widths, defaults, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package slt_pkg;

  // Build-time defaults
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_SIDE_DEF  = 63;
  localparam int MAX_HEIGHT    = 4096;

  // Field and state widths
  localparam int PIX_W   = 8;
  localparam int FW_W    = 11;
  localparam int HGT_W   = 13;
  localparam int HALF_W  = 6;
  localparam int KF_W    = 8;
  localparam int ROW_W   = 12;
  localparam int CSUM_W  = 14;
  localparam int CSQ_W   = 22;
  localparam int COL_W   = CSUM_W + CSQ_W;
  localparam int WSUM_W  = 20;
  localparam int WSQ_W   = 28;
  localparam int N_W     = 14;
  localparam int NN_W    = 2 * N_W;
  localparam int RAD_W   = 42;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int SQ_STEPS = ROOT_W;
  localparam int SQ_CNT_W = $clog2(SQ_STEPS + 1);
  localparam int KFN_W   = KF_W + N_W;
  localparam int KFR_W   = KF_W + ROOT_W;
  localparam int BRK_W   = 31;
  localparam int LHS_W   = PIX_W + NN_W;
  localparam int PROD_W  = 52;
  localparam int FRAC_SH = 15;

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Register reset values
  localparam logic [FW_W-1:0]   RST_WIDTH  = FW_W'(1024);
  localparam logic [HGT_W-1:0]  RST_HEIGHT = HGT_W'(1024);
  localparam logic [HALF_W-1:0] RST_HALF   = HALF_W'(8);
  localparam logic [KF_W-1:0]   RST_KFRAC  = KF_W'(128);

  typedef enum logic [1:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_HALF,
    REG_KFRAC
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD0,
    S_RD1,
    S_WR,
    S_MUL,
    S_SUB,
    S_ROOT,
    S_BRK,
    S_SUM,
    S_PROD,
    S_EMIT
  } seq_state_e;

endpackage

@@ hw/rtl/sauvola_local_threshold.sv @@
// ----------------------------------------------------------------------------
// Sauvola local threshold binarizer
// Windowed mean and deviation from line and column-sum memories, one bit out.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the border-padded frame on pixel_i in raster order with
//   in_valid_i/in_ready_o. One beat on white_o/line_end_o comes out for each
//   interior pixel, at the beat that delivers its window's bottom-right pixel.
//   Program geometry and k through the APB port while the block is idle.
// Sequence:
//   A pixel that yields no result is accepted, then reads the old line pixel
//   and column sums, reads the centre and trailing column, and writes back.
//   A pixel that yields a result goes through the same steps, then the
//   products, a 21-step root iteration on two radicand bits per step, and
//   the final compare.
// Reset:
//   Configuration registers take their default values; then a clearing pass
//   zeroes every column-sum memory entry, with in_ready_o low.
// Stall:
//   The result sits in an output register; a stalled receiver holds the
//   sequencer only when the next result is ready to load.
// ----------------------------------------------------------------------------
`include "sauvola_local_threshold_macros.svh"

module sauvola_local_threshold import slt_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int MAX_SIDE  = MAX_SIDE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // pixel in
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [PIX_W-1:0]   pixel_i,
  // result out
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               white_o,
  output logic               line_end_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int CW          = $clog2(MAX_WIDTH);
  localparam int WW          = $clog2(MAX_WIDTH + 1);
  localparam int STORE_LINES = MAX_SIDE + 1;
  localparam int SLW         = $clog2(STORE_LINES);
  localparam int DMAX        = (MAX_SIDE + 1) / 2;
  localparam int DW          = $clog2(DMAX + 1);
  localparam int SW          = $clog2(MAX_SIDE + 1);
  localparam int LS_DEPTH    = STORE_LINES * (2 ** CW);
  localparam int LS_AW       = SLW + CW;

  // ---------------------------------------------------------------- config
  logic [FW_W-1:0]   cfg_width_q;
  logic [HGT_W-1:0]  cfg_height_q;
  logic [HALF_W-1:0] cfg_half_q;
  logic [KF_W-1:0]   cfg_kf_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= RST_WIDTH;
      cfg_height_q <= RST_HEIGHT;
      cfg_half_q   <= RST_HALF;
      cfg_kf_q     <= RST_KFRAC;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_WIDTH:  cfg_width_q  <= pwdata[FW_W-1:0];
        REG_HEIGHT: cfg_height_q <= pwdata[HGT_W-1:0];
        REG_HALF:   cfg_half_q   <= pwdata[HALF_W-1:0];
        REG_KFRAC:  cfg_kf_q     <= pwdata[KF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_WIDTH:  prdata = PDATA_W'(cfg_width_q);
      REG_HEIGHT: prdata = PDATA_W'(cfg_height_q);
      REG_HALF:   prdata = PDATA_W'(cfg_half_q);
      REG_KFRAC:  prdata = PDATA_W'(cfg_kf_q);
      default:    prdata = '0;
    endcase
  end

  // Saturated geometry
  logic [WW-1:0]    w_lim;
  logic [HGT_W-1:0] h_lim;
  logic [DW-1:0]    d_lim;
  logic [DW-1:0]    dm1;
  logic [SW-1:0]    side;

  always_comb begin
    if (cfg_width_q < FW_W'(3)) begin
      w_lim = WW'(3);
    end else if (32'(cfg_width_q) > 32'(MAX_WIDTH)) begin
      w_lim = WW'(MAX_WIDTH);
    end else begin
      w_lim = WW'(cfg_width_q);
    end
    if (cfg_height_q < HGT_W'(3)) begin
      h_lim = HGT_W'(3);
    end else if (32'(cfg_height_q) > 32'(MAX_HEIGHT)) begin
      h_lim = HGT_W'(MAX_HEIGHT);
    end else begin
      h_lim = cfg_height_q;
    end
    if (cfg_half_q < HALF_W'(2)) begin
      d_lim = DW'(2);
    end else if (32'(cfg_half_q) > 32'(DMAX)) begin
      d_lim = DW'(DMAX);
    end else begin
      d_lim = DW'(cfg_half_q);
    end
    dm1  = d_lim - DW'(1);
    side = SW'(2 * 32'(d_lim) - 1);
  end

  logic [N_W-1:0] n_q;

  always_ff @(posedge clk_i) begin
    n_q <= N_W'(side) * N_W'(side);
  end

  // ---------------------------------------------------------------- helpers
  function automatic logic [SLW-1:0] slot_inc(input logic [SLW-1:0] s);
    logic [SLW-1:0] r;
    begin
      r = (s == SLW'(STORE_LINES - 1)) ? '0 : s + SLW'(1);
      return r;
    end
  endfunction

  // slot - x modulo the line count; x stays below the line count
  function automatic logic [SLW-1:0] slot_sub(input logic [SLW-1:0] s,
                                              input logic [SW-1:0] x);
    int v;
    begin
      v = int'(s) - int'(x);
      if (v < 0) begin
        v = v + STORE_LINES;
      end
      return SLW'(v);
    end
  endfunction

  // ---------------------------------------------------------------- state
  seq_state_e state_q, state_d;

  logic [CW-1:0]     clr_q;
  logic [CW-1:0]     col_q;
  logic [ROW_W-1:0]  row_q;
  logic [SLW-1:0]    slot_q;
  logic [CW-1:0]     cur_c_q;
  logic [ROW_W-1:0]  cur_r_q;
  logic [SLW-1:0]    cur_slot_q;
  logic [PIX_W-1:0]  pix_q;
  logic [PIX_W-1:0]  centre_q;
  logic [CSUM_W-1:0] new_s_q;
  logic [CSQ_W-1:0]  new_q_q;
  logic [WSUM_W-1:0] wsum_q;
  logic [WSQ_W-1:0]  wsq_q;
  logic [RAD_W-1:0]  nq_q;
  logic [2*WSUM_W-1:0] ss_q;
  logic [NN_W-1:0]   nn_q;
  logic [RAD_W-1:0]  rad_q;
  logic [ROOT_W+2:0] rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [SQ_CNT_W-1:0] sq_cnt_q;
  logic [KFN_W-1:0]  kfn_q;
  logic [KFR_W-1:0]  kfr_q;
  logic [BRK_W-1:0]  brk_q;
  logic [PROD_W-1:0] rhs_q;
  logic [LHS_W-1:0]  lhs_q;
  logic              line_end_q;
  logic              out_valid_q;
  logic              white_q;
  logic              out_line_end_q;

  // Memories
  logic              ls_we;
  logic [LS_AW-1:0]  ls_addr;
  logic [PIX_W-1:0]  ls_rdata;
  logic              col_we;
  logic [CW-1:0]     col_addr;
  logic [COL_W-1:0]  col_wdata;
  logic [COL_W-1:0]  col_rdata;

  slt_ram #(.WIDTH(PIX_W), .DEPTH(LS_DEPTH)) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ls_we),
    .addr_i (ls_addr),
    .wdata_i(pix_q),
    .rdata_o(ls_rdata)
  );

  slt_ram #(.WIDTH(COL_W), .DEPTH(MAX_WIDTH)) u_col_ram (
    .clk_i  (clk_i),
    .we_i   (col_we),
    .addr_i (col_addr),
    .wdata_i(col_wdata),
    .rdata_o(col_rdata)
  );

  // Position of the incoming beat after geometry wrap
  logic [CW-1:0]    acc_c;
  logic [HGT_W-1:0] acc_r;
  logic [SLW-1:0]   acc_s;

  always_comb begin
    acc_c = col_q;
    acc_r = HGT_W'(row_q);
    acc_s = slot_q;
    if (32'(col_q) >= 32'(w_lim)) begin
      acc_c = '0;
      acc_r = acc_r + HGT_W'(1);
      acc_s = slot_inc(slot_q);
    end
    if (32'(acc_r) >= 32'(h_lim)) begin
      acc_r = '0;
      acc_s = '0;
    end
  end

  // Position after the current beat
  logic [CW:0]      nxt_c;
  logic [CW-1:0]    adv_c;
  logic [HGT_W-1:0] adv_r;
  logic [SLW-1:0]   adv_s;

  always_comb begin
    nxt_c = {1'b0, cur_c_q} + (CW+1)'(1);
    adv_c = nxt_c[CW-1:0];
    adv_r = HGT_W'(cur_r_q);
    adv_s = cur_slot_q;
    if (32'(nxt_c) >= 32'(w_lim)) begin
      adv_c = '0;
      adv_r = adv_r + HGT_W'(1);
      adv_s = slot_inc(cur_slot_q);
      if (32'(adv_r) >= 32'(h_lim)) begin
        adv_r = '0;
        adv_s = '0;
      end
    end
  end

  logic emit_hit;
  logic at_end;

  assign emit_hit = (32'(cur_r_q) >= 32'(side)) && (32'(cur_r_q) + 2 <= 32'(h_lim)) &&
                    (32'(cur_c_q) >= 32'(side)) && (32'(cur_c_q) + 2 <= 32'(w_lim));
  assign at_end   = (32'(cur_c_q) + 2 == 32'(w_lim));

  // Column update from the old line pixel and stored column sums
  logic [2*PIX_W-1:0] p2;
  logic [2*PIX_W-1:0] o2;
  logic [CSUM_W-1:0]  upd_s;
  logic [CSQ_W-1:0]   upd_q;

  always_comb begin
    p2 = pix_q * pix_q;
    o2 = ls_rdata * ls_rdata;
    if (cur_r_q == '0) begin
      upd_s = CSUM_W'(pix_q);
      upd_q = CSQ_W'(p2);
    end else if (32'(cur_r_q) < 32'(side)) begin
      upd_s = col_rdata[CSUM_W-1:0] + CSUM_W'(pix_q);
      upd_q = col_rdata[COL_W-1:CSUM_W] + CSQ_W'(p2);
    end else begin
      upd_s = col_rdata[CSUM_W-1:0] + CSUM_W'(pix_q) - CSUM_W'(ls_rdata);
      upd_q = col_rdata[COL_W-1:CSUM_W] + CSQ_W'(p2) - CSQ_W'(o2);
    end
  end

  // Root iteration step
  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;

  assign rem_sh = {rem_q[ROOT_W:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    ls_we      = 1'b0;
    ls_addr    = {cur_slot_q, cur_c_q};
    col_we     = 1'b0;
    col_addr   = cur_c_q;
    col_wdata  = {new_q_q, new_s_q};
    unique case (state_q)
      S_CLEAR: begin
        col_we    = 1'b1;
        col_addr  = clr_q;
        col_wdata = '0;
        if (clr_q == CW'(MAX_WIDTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = S_RD0;
        end
      end
      S_RD0: begin
        // line leaving the window, and this column's sums
        ls_addr  = {slot_sub(cur_slot_q, side), cur_c_q};
        col_addr = cur_c_q;
        state_d  = S_RD1;
      end
      S_RD1: begin
        // centre pixel, and the column leaving the window
        ls_addr  = {slot_sub(cur_slot_q, SW'(dm1)), cur_c_q - CW'(dm1)};
        col_addr = cur_c_q - CW'(side);
        state_d  = S_WR;
      end
      S_WR: begin
        ls_we    = 1'b1;
        ls_addr  = {cur_slot_q, cur_c_q};
        col_we   = 1'b1;
        col_addr = cur_c_q;
        state_d  = emit_hit ? S_MUL : S_IDLE;
      end
      S_MUL:  state_d = S_SUB;
      S_SUB:  state_d = S_ROOT;
      S_ROOT: begin
        if (sq_cnt_q == SQ_CNT_W'(SQ_STEPS - 1)) begin
          state_d = S_BRK;
        end
      end
      S_BRK:  state_d = S_SUM;
      S_SUM:  state_d = S_PROD;
      S_PROD: state_d = S_EMIT;
      S_EMIT: begin
        // hold while the previous result is still waiting
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      col_q    <= '0;
      row_q    <= '0;
      slot_q   <= '0;
      wsum_q   <= '0;
      wsq_q    <= '0;
      sq_cnt_q <= '0;
    end else begin
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + CW'(1);
      end
      if (state_q == S_WR) begin
        col_q  <= adv_c;
        row_q  <= ROW_W'(adv_r);
        slot_q <= adv_s;
        if (cur_c_q == '0) begin
          wsum_q <= WSUM_W'(new_s_q);
          wsq_q  <= WSQ_W'(new_q_q);
        end else if (32'(cur_c_q) >= 32'(side)) begin
          wsum_q <= wsum_q + WSUM_W'(new_s_q) - WSUM_W'(col_rdata[CSUM_W-1:0]);
          wsq_q  <= wsq_q + WSQ_W'(new_q_q) - WSQ_W'(col_rdata[COL_W-1:CSUM_W]);
        end else begin
          wsum_q <= wsum_q + WSUM_W'(new_s_q);
          wsq_q  <= wsq_q + WSQ_W'(new_q_q);
        end
      end
      if (state_q == S_SUB) begin
        sq_cnt_q <= '0;
      end else if (state_q == S_ROOT) begin
        sq_cnt_q <= sq_cnt_q + SQ_CNT_W'(1);
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        cur_c_q    <= acc_c;
        cur_r_q    <= ROW_W'(acc_r);
        cur_slot_q <= acc_s;
        pix_q      <= pixel_i;
      end
      S_RD1: begin
        new_s_q <= upd_s;
        new_q_q <= upd_q;
      end
      S_WR: begin
        centre_q   <= ls_rdata;
        line_end_q <= at_end;
      end
      S_MUL: begin
        nq_q <= n_q * wsq_q;
        ss_q <= wsum_q * wsum_q;
        nn_q <= n_q * n_q;
      end
      S_SUB: begin
        // a negative radicand only follows mid-frame geometry changes
        rad_q  <= (nq_q > RAD_W'(ss_q)) ? nq_q - RAD_W'(ss_q) : '0;
        rem_q  <= '0;
        root_q <= '0;
      end
      S_ROOT: begin
        rad_q <= rad_q << 2;
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[ROOT_W-2:0], 1'b0};
        end
      end
      S_BRK: begin
        kfn_q <= cfg_kf_q * n_q;
        kfr_q <= cfg_kf_q * root_q;
      end
      S_SUM: begin
        brk_q <= BRK_W'({n_q, {FRAC_SH{1'b0}}}) - BRK_W'({kfn_q, 7'b0}) + BRK_W'(kfr_q);
      end
      S_PROD: begin
        rhs_q <= wsum_q * brk_q;
        lhs_q <= centre_q * nn_q;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- output
  logic load_out;

  assign load_out = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      white_q        <= PROD_W'({lhs_q, {FRAC_SH{1'b0}}}) >= rhs_q;
      out_line_end_q <= line_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign white_o     = white_q;
  assign line_end_o  = out_line_end_q;

  // ---------------------------------------------------------------- checks
  `SLT_ASSERT_NEXT(a_one_beat_in_flight, in_valid_i && in_ready_o, !in_ready_o, "second beat taken while busy")
  `SLT_ASSERT(a_root_count, sq_cnt_q <= SQ_CNT_W'(SQ_STEPS), "root step count overran")
  `SLT_ASSERT(a_pos_range, 32'(slot_q) < STORE_LINES && 32'(col_q) < MAX_WIDTH, "position out of range")
  `SLT_ASSERT(a_result_from_emit, $rose(out_valid_q) |-> $past(state_q) == S_EMIT, "result loaded outside emit")

endmodule

@@ hw/rtl/slt_ram.sv @@
// ----------------------------------------------------------------------------
// Sauvola local threshold - single-port RAM
// One address per cycle, synchronous write, registered read (read-first).
// ----------------------------------------------------------------------------
module slt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// Sauvola local threshold - block-level testbench
// A predictor tracks the line store, the column and window sums
// and the geometry registers. Each pixel beat accepted by the block updates
// that predictor, which queues the expected white/line_end bits. Results are
// compared in order. Reset values, directed frames, register saturation,
// mid-frame geometry changes, back-pressure and random frames run in turn.
// ----------------------------------------------------------------------------
module tb_top;
  import slt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_ROWS = MAX_SIDE_DEF + 1;
  localparam int SETTLE     = 40;

  typedef struct packed {
    bit white;
    bit line_end;
  } thr_result_t;

  typedef enum int {PM_RANDOM, PM_FLAT, PM_DARK, PM_BRIGHT, PM_CHECKER, PM_EXTREME} pix_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [PIX_W-1:0]   pixel_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               white_o;
  logic               line_end_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  sauvola_local_threshold u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .pixel_i,
    .out_valid_o, .out_ready_i, .white_o, .line_end_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Predictor state
  bit [FW_W-1:0]   cfg_width  = RST_WIDTH;
  bit [HGT_W-1:0]  cfg_height = RST_HEIGHT;
  bit [HALF_W-1:0] cfg_half   = RST_HALF;
  bit [KF_W-1:0]   cfg_kfrac  = RST_KFRAC;
  bit [PIX_W-1:0]  line_mem [STORE_ROWS*MAX_WIDTH_DEF];
  bit [CSUM_W-1:0] col_sum [MAX_WIDTH_DEF];
  bit [CSQ_W-1:0]  col_sq [MAX_WIDTH_DEF];
  bit [WSUM_W-1:0] win_sum;
  bit [WSQ_W-1:0]  win_sq;
  int unsigned     row_pos, col_pos;

  thr_result_t expected_bits[$];
  int          mismatches = 0;
  bit          tx_no_idle = 0, rx_no_idle = 0;
  int          rx_hold = 0;
  int unsigned pixel_count = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, cand;
    r = 0;
    for (int i = 21; i >= 0; i--) begin
      cand = r | (64'd1 << i);
      if (cand * cand <= v) r = cand;
    end
    return r;
  endfunction

  // Advance the predictor by one accepted pixel.
  task automatic threshold_predict(bit [PIX_W-1:0] p);
    int unsigned w, h, d, side, r, c, slot, old_slot, cr, cc;
    bit [PIX_W-1:0] old;
    bit [CSQ_W-1:0] pp, oo;
    longint unsigned n, s, q, nq, ss, root, kf, bracket, lhs, rhs, centre;
    thr_result_t res;
    w = clip(cfg_width, 3, MAX_WIDTH_DEF);
    h = clip(cfg_height, 3, MAX_HEIGHT);
    d = clip(cfg_half, 2, (MAX_SIDE_DEF + 1) / 2);
    side = 2 * d - 1;
    r = row_pos;
    c = col_pos;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r >= h) r = 0;
    slot = r % STORE_ROWS;
    old_slot = (r + STORE_ROWS - side) % STORE_ROWS;
    old = line_mem[old_slot*MAX_WIDTH_DEF + c];
    pp = p * p;
    oo = old * old;
    if (r == 0) begin
      col_sum[c] = p;
      col_sq[c] = pp;
    end else if (r < side) begin
      col_sum[c] = col_sum[c] + p;
      col_sq[c] = col_sq[c] + pp;
    end else begin
      col_sum[c] = col_sum[c] + p - old;
      col_sq[c] = col_sq[c] + pp - oo;
    end
    line_mem[slot*MAX_WIDTH_DEF + c] = p;
    if (c == 0) begin
      win_sum = col_sum[0];
      win_sq = col_sq[0];
    end else begin
      win_sum = win_sum + col_sum[c];
      win_sq = win_sq + col_sq[c];
      if (c >= side) begin
        win_sum = win_sum - col_sum[c-side];
        win_sq = win_sq - col_sq[c-side];
      end
    end
    if (r >= side && r + 2 <= h && c >= side && c + 2 <= w) begin
      cr = r - (d - 1);
      cc = c - (d - 1);
      centre = line_mem[(cr % STORE_ROWS)*MAX_WIDTH_DEF + cc];
      n = side * side;
      s = win_sum;
      q = win_sq;
      nq = n * q;
      ss = s * s;
      root = nq > ss ? floor_root(nq - ss) : 0;
      kf = cfg_kfrac;
      bracket = 32768 * n - 128 * kf * n + kf * root;
      lhs = centre * 32768 * n * n;
      rhs = s * bracket;
      res.white = lhs >= rhs;
      res.line_end = (c + 2 == w);
      expected_bits.push_back(res);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    row_pos = r & 12'hFFF;
    col_pos = c & 10'h3FF;
  endtask

  // Receiver: check each result beat, then draw the next stall.
  initial begin
    int stall;
    thr_result_t exp_r;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (expected_bits.size() == 0) begin
          $display("%0t: unexpected result white=%0b line_end=%0b", $time, white_o,
                   line_end_o);
          mismatches++;
        end else begin
          exp_r = expected_bits.pop_front();
          if (white_o !== exp_r.white) begin
            $display("%0t: white expected %0b actual %0b", $time, exp_r.white, white_o);
            mismatches++;
          end
          if (line_end_o !== exp_r.line_end) begin
            $display("%0t: line_end expected %0b actual %0b", $time, exp_r.line_end,
                     line_end_o);
            mismatches++;
          end
        end
        stall = rx_no_idle ? 0 : $urandom_range(0, 6);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready_i <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic bit [PIX_W-1:0] draw_pixel(pix_mode_e mode);
    case (mode)
      PM_FLAT:    return 8'd137;
      PM_DARK:    return $urandom_range(0, 40);
      PM_BRIGHT:  return $urandom_range(215, 255);
      PM_CHECKER: return pixel_count[0] ? 8'd255 : 8'd0;
      PM_EXTREME: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default:    return $urandom_range(0, 255);
    endcase
  endfunction

  // Send one pixel beat; valid stays high when no gap follows.
  task automatic send_pixel(bit [PIX_W-1:0] p);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    pixel_count++;
    threshold_predict(p);
  endtask

  task automatic send_pixels(int unsigned count, pix_mode_e mode);
    repeat (count) send_pixel(draw_pixel(mode));
  endtask

  // Pad out the current frame so the next one starts at row 0, column 0.
  task automatic finish_frame(pix_mode_e mode);
    while (row_pos != 0 || col_pos != 0) send_pixel(draw_pixel(mode));
  endtask

  // Drop valid and wait until every result is in and the block is quiet.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_bits.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_idx_e idx, bit [PDATA_W-1:0] value);
    // never change a register under a beat in flight
    drain();
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * idx);
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_WIDTH:  cfg_width = value[FW_W-1:0];
      REG_HEIGHT: cfg_height = value[HGT_W-1:0];
      REG_HALF:   cfg_half = value[HALF_W-1:0];
      default:    cfg_kfrac = value[KF_W-1:0];
    endcase
  endtask

  task automatic reg_check(reg_idx_e idx, bit [PDATA_W-1:0] want);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= PADDR_W'(4 * idx);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      $display("%0t: register %s expected %0d actual %0d", $time, idx.name(), want, prdata);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h, int unsigned d, int unsigned k);
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
    reg_write(REG_HALF, d);
    reg_write(REG_KFRAC, k);
  endtask

  task automatic test_reset_values();
    reg_check(REG_WIDTH, RST_WIDTH);
    reg_check(REG_HEIGHT, RST_HEIGHT);
    reg_check(REG_HALF, RST_HALF);
    reg_check(REG_KFRAC, RST_KFRAC);
  endtask

  task automatic test_directed_frames();
    set_geometry(5, 5, 2, 0);
    reg_check(REG_WIDTH, 5);
    send_pixels(25, PM_BRIGHT);
    reg_write(REG_KFRAC, 255);
    reg_check(REG_KFRAC, 255);
    send_pixels(25, PM_EXTREME);
    send_pixels(25, PM_CHECKER);
    reg_write(REG_KFRAC, 128);
    send_pixels(25, PM_DARK);
    set_geometry(7, 6, 2, 77);
    send_pixels(42, PM_FLAT);
    send_pixels(42, PM_RANDOM);
    drain();
  endtask

  // Out-of-range register values clamp inside the block.
  task automatic test_saturation();
    set_geometry(0, 7, 0, 200);
    send_pixels(3 * 7, PM_RANDOM);
    drain();
    // oversized width: part of one long line, then fall back to the narrowest
    set_geometry(2047, 5, 1, 60);
    send_pixels(40, PM_RANDOM);
    reg_write(REG_WIDTH, 0);
    finish_frame(PM_RANDOM);
    drain();
    set_geometry(7, 0, 2, 90);
    send_pixels(7 * 3, PM_RANDOM);
    drain();
    // oversized window on a small frame
    set_geometry(9, 9, 63, 255);
    send_pixels(9 * 9, PM_RANDOM);
    drain();
    // frame too small for the window
    set_geometry(4, 4, 2, 128);
    send_pixels(32, PM_RANDOM);
    drain();
  endtask

  // Shrink width, then height, part way through a frame; then enlarge the window.
  task automatic test_midframe_change();
    set_geometry(8, 8, 2, 100);
    send_pixels(30, PM_RANDOM);
    drain();
    reg_write(REG_WIDTH, 5);
    finish_frame(PM_RANDOM);
    drain();
    set_geometry(6, 8, 2, 150);
    send_pixels(40, PM_RANDOM);
    drain();
    reg_write(REG_HEIGHT, 5);
    send_pixels(30, PM_RANDOM);
    finish_frame(PM_RANDOM);
    drain();
    reg_write(REG_HALF, 3);
    send_pixels(6 * 5, PM_RANDOM);
    drain();
  endtask

  // Hold the receiver off long enough to fill the block, then pause the sender.
  task automatic test_backpressure();
    set_geometry(9, 7, 2, 128);
    tx_no_idle = 1;
    rx_hold = 400;
    send_pixels(63, PM_RANDOM);
    send_pixels(30, PM_RANDOM);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_bits.size() != 0);
    finish_frame(PM_RANDOM);
    tx_no_idle = 0;
    drain();
  endtask

  task automatic test_random_frames();
    int unsigned sent, w, h, d, reps;
    pix_mode_e mode;
    sent = 0;
    while (sent < 120) begin
      d = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 5) : $urandom_range(2, 3);
      w = $urandom_range(2 * d + 1, 2 * d + 8);
      h = $urandom_range(2 * d + 1, 2 * d + 5);
      if ($urandom_range(0, 9) == 0) w = $urandom_range(3, 2 * d);
      set_geometry(w, h, d, $urandom_range(0, 255));
      tx_no_idle = ($urandom_range(0, 3) == 0);
      rx_no_idle = ($urandom_range(0, 3) == 0);
      mode = pix_mode_e'(($urandom_range(0, 9) < 5) ? PM_RANDOM : $urandom_range(1, 5));
      reps = $urandom_range(1, 2);
      repeat (reps) send_pixels(clip(w, 3, 1024) * h, mode);
      sent += reps * clip(w, 3, 1024) * h;
      drain();
    end
    tx_no_idle = 0;
    rx_no_idle = 0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_values();
    test_directed_frames();
    test_saturation();
    test_midframe_change();
    test_backpressure();
    test_random_frames();
    drain();
    if (mismatches == 0 && expected_bits.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
